/* src/fcb_pkg.sv */
// Shared types and mixing functions for the 32-bit Feistel block cipher.
// Used by fcb_cell and feistel_cipher_32bit_block_top; no other dependencies.
`default_nettype none

package fcb_pkg;

  typedef logic [15:0]      word_t;
  typedef logic [7:0][15:0] subkeys_t;

  // Configuration register indexes.
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // Operation codes carried in tuser.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // One word as it moves from cell to cell.
  typedef struct packed {
    logic  valid;
    logic  op;
    word_t left;
    word_t right;
  } stage_t;

  // A word inside a cell, together with the partly mixed value.
  typedef struct packed {
    stage_t st;
    word_t  t;
  } mid_t;

  // The forward mix, split into three parts of one shift-add and one xorshift each.
  function automatic word_t enc_part1(input word_t a);
    word_t x;
    x = a + (a << 7);
    x = x ^ (x >> 8);
    return x;
  endfunction

  function automatic word_t enc_part2(input word_t a);
    word_t x;
    x = a + (a << 3);
    x = x ^ (x >> 2);
    return x;
  endfunction

  function automatic word_t enc_part3(input word_t a);
    word_t x;
    x = a + (a << 4);
    x = x ^ (x >> 8);
    return x;
  endfunction

  // The inverse mix, split so that each part ends in one constant multiply.
  function automatic word_t dec_part1(input word_t a);
    word_t x;
    x = a ^ (a >> 8);
    x = x * 16'hF0F1;
    return x;
  endfunction

  function automatic word_t dec_part2(input word_t a);
    word_t x;
    x = a ^ (a >> 2) ^ (a >> 4) ^ (a >> 6) ^ (a >> 8) ^ (a >> 10) ^ (a >> 12) ^ (a >> 14);
    x = x * 16'h8E39;
    return x;
  endfunction

  function automatic word_t dec_part3(input word_t a);
    word_t x;
    x = a ^ (a >> 8);
    x = x * 16'h3F81;
    return x;
  endfunction

endpackage

`default_nettype wire

/* src/fcb_cell.sv */
// One half-round cell of the Feistel chain, three register stages deep.
// Depends on fcb_pkg for the word types and the mixing functions.
`default_nettype none

module fcb_cell
  import fcb_pkg::*;
#(
  parameter int ENC_ROUND = 1,
  parameter int DEC_ROUND = 1
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     adv,
  input  wire subkeys_t subkeys,
  input  wire stage_t   cell_in,
  output      stage_t   cell_out
);

  localparam word_t      ENC_RC  = 16'(ENC_ROUND);
  localparam word_t      DEC_RC  = 16'(DEC_ROUND);
  localparam logic [2:0] ENC_KEY = 3'(ENC_ROUND % 8);
  localparam logic [2:0] DEC_KEY = 3'(DEC_ROUND % 8);

  mid_t   s1;
  mid_t   s2;
  stage_t s3;
  mid_t   s1_next;
  mid_t   s2_next;
  stage_t s3_next;
  word_t  t_in;
  word_t  f_enc;
  word_t  r_dec;

  always_comb begin
    if (cell_in.op == OP_DECRYPT) begin
      // Left xor right recovers the round function output; strip the round number.
      t_in = dec_part1((cell_in.left ^ cell_in.right) - DEC_RC);
    end else begin
      t_in = enc_part1(cell_in.right ^ subkeys[ENC_KEY]);
    end
    s1_next.st = cell_in;
    s1_next.t  = t_in;
  end

  always_comb begin
    s2_next.st = s1.st;
    s2_next.t  = (s1.st.op == OP_DECRYPT) ? dec_part2(s1.t) : enc_part2(s1.t);
  end

  always_comb begin
    f_enc         = enc_part3(s2.t) + ENC_RC;
    r_dec         = dec_part3(s2.t) ^ subkeys[DEC_KEY];
    s3_next.valid = s2.st.valid;
    s3_next.op    = s2.st.op;
    if (s2.st.op == OP_DECRYPT) begin
      s3_next.left  = s2.st.right;
      s3_next.right = r_dec;
    end else begin
      s3_next.left  = s2.st.left ^ f_enc;
      s3_next.right = s2.st.left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.st.valid <= 1'b0;
      s2.st.valid <= 1'b0;
      s3.valid    <= 1'b0;
    end else if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

  assign cell_out = s3;

endmodule

`default_nettype wire

/* src/feistel_cipher_32bit_block_top.sv */
// Top level of the 32-bit Feistel block cipher: key registers, cell chain, output register.
// Depends on fcb_pkg and fcb_cell.
`default_nettype none

// Encrypts or decrypts one 32-bit word per clock cycle when the chain does not stall.
// Each half-round is one cell of three register stages, as the inverse mix holds three
// chained constant multiplies; a word passes the three registers of each cell, then the
// output register. The chain moves as a whole: it stalls only when its last cell holds a
// word and the output register still holds one not yet taken. The user must write keys
// through the configuration port while no word is in flight; the block does not enforce it.
module feistel_cipher_32bit_block_top
  import fcb_pkg::*;
#(
  parameter int HALF_ROUNDS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // block_in[31:0]
  input  wire logic        s_tuser,   // op[0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata    // block_out[31:0]
);

  logic [63:0] key_low_half;
  logic [63:0] key_high_half;
  subkeys_t    subkeys;
  stage_t      link [HALF_ROUNDS+1];
  logic        adv;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_half  <= '0;
      key_high_half <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_KEY_LOW) begin
        key_low_half <= cfg_data;
      end else begin
        key_high_half <= cfg_data;
      end
    end
  end

  assign subkeys = {key_high_half, key_low_half};

  assign out_free = !m_tvalid || m_tready;
  assign adv      = !link[HALF_ROUNDS].valid || out_free;
  assign s_tready = adv;

  always_comb begin
    link[0].valid = s_tvalid;
    link[0].op    = s_tuser;
    link[0].left  = s_tdata[31:16];
    link[0].right = s_tdata[15:0];
  end

  for (genvar g = 0; g < HALF_ROUNDS; g++) begin : g_cell
    fcb_cell #(
      .ENC_ROUND(g + 1),
      .DEC_ROUND(HALF_ROUNDS - g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .subkeys (subkeys),
      .cell_in (link[g]),
      .cell_out(link[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= link[HALF_ROUNDS].valid;
      m_tdata  <= {link[HALF_ROUNDS].left, link[HALF_ROUNDS].right};
    end
  end

  // A finished word with nowhere to go must hold the whole chain.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && link[HALF_ROUNDS].valid) |-> !s_tready)
    else $error("input taken while the chain is stalled");

  // A word leaving the last cell into a free output register must be shown next cycle.
  a_word_reaches_output : assert property (@(posedge clk) disable iff (rst)
    (link[HALF_ROUNDS].valid && out_free) |=> m_tvalid)
    else $error("word lost between the last cell and the output register");

  // Reset leaves no result pending.
  a_reset_empties_output : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending straight after reset");

endmodule

`default_nettype wire
